// ===== hw/rtl/interval_booking_table_unit_macros.svh =====
// assertion macros for the interval booking table
// used by interval_booking_table_unit; expects i_clk and i_rst_n in scope
`ifndef INTERVAL_BOOKING_TABLE_UNIT_MACROS_SVH
`define INTERVAL_BOOKING_TABLE_UNIT_MACROS_SVH

// check that is masked while reset is held
`define IBT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check that also holds through reset
`define IBT_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/ibt_pkg.sv =====
// shared types and constants for the interval booking table
// no dependencies; used by ibt_cell, interval_booking_table_unit and the testbench
`timescale 1ns / 1ps

package ibt_pkg;

    localparam int MAX_INTERVALS = 64;
    localparam int TIME_BITS     = 32;
    localparam int CNT_BITS      = $clog2(MAX_INTERVALS + 1);

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CNT_BITS-1:0]  t_count;

    // status codes of a result
    typedef logic [1:0] t_status;
    localparam t_status ST_BOOKED  = 2'd0;
    localparam t_status ST_RANGE   = 2'd1;
    localparam t_status ST_OVERLAP = 2'd2;
    localparam t_status ST_FULL    = 2'd3;

    // table operation broadcast to the cell row
    typedef enum logic [2:0] {
        OP_NONE,
        OP_JOIN,
        OP_EXT_END,
        OP_EXT_START,
        OP_INSERT
    } t_op;

    // per-cell match flags
    typedef struct packed {
        logic ovl;
        logic left;
        logic right;
    } t_cell_flags;

endpackage

// ===== hw/rtl/ibt_cell.sv =====
// one cell of the interval row: holds one stored interval
// depends on ibt_pkg; compares against the request and shifts with neighbors
`timescale 1ns / 1ps

module ibt_cell (
    input  logic                i_clk,
    input  ibt_pkg::t_time      i_s,
    input  ibt_pkg::t_time      i_e,
    input  logic                i_occ,
    input  logic                i_apply,
    input  ibt_pkg::t_op        i_op,
    input  ibt_pkg::t_time      i_lo_start,
    input  ibt_pkg::t_time      i_lo_end,
    input  logic                i_lo_lt,
    input  ibt_pkg::t_time      i_hi_start,
    input  ibt_pkg::t_time      i_hi_end,
    output ibt_pkg::t_time      o_start,
    output ibt_pkg::t_time      o_end,
    output logic                o_lt,
    output ibt_pkg::t_cell_flags o_flags
);

    ibt_pkg::t_time      r_start;
    ibt_pkg::t_time      r_end;
    ibt_pkg::t_cell_flags r_flags;
    logic                r_lt;
    logic                r_ge;

    // compare flags, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_flags.ovl   <= i_occ && (r_start < i_e) && (i_s < r_end);
        r_flags.left  <= i_occ && (r_end == i_s);
        r_flags.right <= i_occ && (r_start == i_e);
        r_lt          <= i_occ && (r_start < i_s);
        r_ge          <= i_occ && (r_start >= i_e);
    end

    // entry update
    always_ff @(posedge i_clk) begin
        if (i_apply) begin
            case (i_op)
                ibt_pkg::OP_JOIN: begin
                    if (r_flags.left) begin
                        r_end <= i_hi_end;
                    end else if (r_ge) begin
                        r_start <= i_hi_start;
                        r_end   <= i_hi_end;
                    end
                end
                ibt_pkg::OP_EXT_END: begin
                    if (r_flags.left) begin
                        r_end <= i_e;
                    end
                end
                ibt_pkg::OP_EXT_START: begin
                    if (r_flags.right) begin
                        r_start <= i_s;
                    end
                end
                ibt_pkg::OP_INSERT: begin
                    if (!r_lt) begin
                        if (i_lo_lt) begin
                            r_start <= i_s;
                            r_end   <= i_e;
                        end else begin
                            r_start <= i_lo_start;
                            r_end   <= i_lo_end;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_lt    = r_lt;
    assign o_flags = r_flags;

endmodule

// ===== hw/rtl/interval_booking_table_unit.sv =====
// the result register loads in the update state once the output is free, after compare and decide
// a new request is taken only while idle and runs through take, compare, decide, update of the cell row
// a result held in a stalled output register does not block the next request; a later one waits
// reset: stored count and handshake state clear; cell contents stay undefined until written
// top level of the interval booking table; depends on ibt_pkg, ibt_cell and
// interval_booking_table_unit_macros.svh
`timescale 1ns / 1ps
`include "interval_booking_table_unit_macros.svh"

module interval_booking_table_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  ibt_pkg::t_time   i_req_start,
    input  ibt_pkg::t_time   i_req_end,
    output logic             o_res_valid,
    input  logic             i_res_stall,
    output logic             o_accepted,
    output ibt_pkg::t_status o_status,
    output ibt_pkg::t_count  o_stored_count
);

    localparam int N = ibt_pkg::MAX_INTERVALS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_DEC,
        S_UPD,
        S_WAIT
    } t_state;

    t_state           r_state;
    ibt_pkg::t_time   r_s;
    ibt_pkg::t_time   r_e;
    ibt_pkg::t_count  r_count;
    ibt_pkg::t_count  r_next_count;
    ibt_pkg::t_status r_res_status;
    ibt_pkg::t_op     r_op;
    logic             r_o_valid;
    logic             r_o_accepted;
    ibt_pkg::t_status r_o_status;
    ibt_pkg::t_count  r_o_count;

    ibt_pkg::t_time   w_start [N];
    ibt_pkg::t_time   w_end   [N];
    logic [N-1:0]     w_lt;
    logic [N-1:0]     w_occ;
    logic [N-1:0]     w_ovl_vec;
    logic [N-1:0]     w_left_vec;
    logic [N-1:0]     w_right_vec;
    ibt_pkg::t_cell_flags w_flags [N];

    ibt_pkg::t_op     n_op;
    ibt_pkg::t_status n_status;
    ibt_pkg::t_count  n_count;
    logic             w_take;
    logic             w_out_free;
    logic             w_res_load;

    // cell row
    for (genvar g = 0; g < N; g++) begin : g_cell
        ibt_pkg::t_time w_lo_start;
        ibt_pkg::t_time w_lo_end;
        logic           w_lo_lt;
        ibt_pkg::t_time w_hi_start;
        ibt_pkg::t_time w_hi_end;

        if (g == 0) begin : g_first
            assign w_lo_start = '0;
            assign w_lo_end   = '0;
            assign w_lo_lt    = 1'b1;
        end else begin : g_mid
            assign w_lo_start = w_start[g-1];
            assign w_lo_end   = w_end[g-1];
            assign w_lo_lt    = w_lt[g-1];
        end

        if (g == N - 1) begin : g_last
            assign w_hi_start = '0;
            assign w_hi_end   = '0;
        end else begin : g_low
            assign w_hi_start = w_start[g+1];
            assign w_hi_end   = w_end[g+1];
        end

        assign w_occ[g] = (r_count > ibt_pkg::t_count'(g));

        ibt_cell u_cell (
            .i_clk      (i_clk),
            .i_s        (r_s),
            .i_e        (r_e),
            .i_occ      (w_occ[g]),
            .i_apply    (r_state == S_UPD),
            .i_op       (r_op),
            .i_lo_start (w_lo_start),
            .i_lo_end   (w_lo_end),
            .i_lo_lt    (w_lo_lt),
            .i_hi_start (w_hi_start),
            .i_hi_end   (w_hi_end),
            .o_start    (w_start[g]),
            .o_end      (w_end[g]),
            .o_lt       (w_lt[g]),
            .o_flags    (w_flags[g])
        );

        assign w_ovl_vec[g]   = w_flags[g].ovl;
        assign w_left_vec[g]  = w_flags[g].left;
        assign w_right_vec[g] = w_flags[g].right;
    end

    // decide the operation from the registered cell flags
    always_comb begin
        n_op     = ibt_pkg::OP_NONE;
        n_status = ibt_pkg::ST_BOOKED;
        n_count  = r_count;
        if (r_e <= r_s) begin
            n_status = ibt_pkg::ST_RANGE;
        end else if (|w_ovl_vec) begin
            n_status = ibt_pkg::ST_OVERLAP;
        end else if ((|w_left_vec) && (|w_right_vec)) begin
            n_op    = ibt_pkg::OP_JOIN;
            n_count = r_count - ibt_pkg::t_count'(1);
        end else if (|w_left_vec) begin
            n_op = ibt_pkg::OP_EXT_END;
        end else if (|w_right_vec) begin
            n_op = ibt_pkg::OP_EXT_START;
        end else if (r_count >= ibt_pkg::t_count'(N)) begin
            n_status = ibt_pkg::ST_FULL;
        end else begin
            n_op    = ibt_pkg::OP_INSERT;
            n_count = r_count + ibt_pkg::t_count'(1);
        end
    end

    assign w_take     = i_req_valid && (r_state == S_IDLE);
    assign w_out_free = !r_o_valid || !i_res_stall;
    // result moves into the output register this cycle
    assign w_res_load = ((r_state == S_UPD) || (r_state == S_WAIT)) && w_out_free;

    // sequencer, stored count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_op      <= ibt_pkg::OP_NONE;
        end else begin
            if (w_res_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_s     <= i_req_start;
                        r_e     <= i_req_end;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_op         <= n_op;
                    r_res_status <= n_status;
                    r_next_count <= n_count;
                    r_state      <= S_UPD;
                end
                S_UPD, S_WAIT: begin
                    r_op    <= ibt_pkg::OP_NONE;
                    r_count <= r_next_count;
                    if (w_out_free) begin
                        r_o_accepted <= (r_res_status == ibt_pkg::ST_BOOKED);
                        r_o_status   <= r_res_status;
                        r_o_count    <= r_next_count;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_stall    = (r_state != S_IDLE);
    assign o_res_valid    = r_o_valid;
    assign o_accepted     = r_o_accepted;
    assign o_status       = r_o_status;
    assign o_stored_count = r_o_count;

    // checks
    `IBT_CHECK(a_count_bound, r_count <= ibt_pkg::t_count'(N), "stored count above capacity")
    `IBT_CHECK(a_count_only_upd, (r_state != S_UPD && r_state != S_WAIT) |=> (r_count == $past(r_count)), "stored count changed outside update")
    `IBT_CHECK(a_one_left, (r_state == S_DEC) |-> $onehot0(w_left_vec), "more than one left neighbor")
    `IBT_CHECK(a_one_right, (r_state == S_DEC) |-> $onehot0(w_right_vec), "more than one right neighbor")
    `IBT_CHECK(a_take_starts, w_take |=> (r_state == S_CMP), "taken request did not start compare")

endmodule

// ===== tb/interval_booking_table_unit_test.sv =====
// self-checking testbench for interval_booking_table_unit: booking requests with
// random gaps and output stalls, results checked against an in-bench booking table
// depends on ibt_pkg and interval_booking_table_unit
`timescale 1ns / 1ps

module interval_booking_table_unit_test;

    import ibt_pkg::*;

    localparam int     PLAN       = 0;   // table copy the request planner keeps
    localparam int     MODEL      = 1;   // table copy that predicts the dut
    localparam int     N_RANDOM   = 850;
    localparam int     PRINT_MAX  = 40;
    localparam longint TIME_TOP   = (longint'(1) << TIME_BITS) - 1;

    typedef struct packed {
        t_time start;
        t_time stop;
    } booking_req_t;

    typedef struct packed {
        logic    accepted;
        t_status status;
        t_count  count;
    } booking_res_t;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   req_valid = 1'b0;
    t_time  req_start = '0;
    t_time  req_end   = '0;
    logic   res_stall = 1'b0;
    logic   req_stall;
    logic   res_valid;
    logic   res_accepted;
    t_status res_status;
    t_count res_count;

    // two copies of the booking table: sorted starts, ends and entry count
    t_time       slot_lo  [2][MAX_INTERVALS];
    t_time       slot_hi  [2][MAX_INTERVALS];
    int unsigned slot_cnt [2] = '{0, 0};

    booking_req_t pending_q [$];
    booking_res_t booked_q  [$];
    booking_res_t head_res;

    int unsigned send_gap    = 0;
    int unsigned send_burst  = 0;
    int unsigned hold_left   = 0;
    int unsigned calm_left   = 0;
    int unsigned err_count   = 0;
    int unsigned res_seen    = 0;

    interval_booking_table_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .o_req_stall    (req_stall),
        .i_req_start    (req_start),
        .i_req_end      (req_end),
        .o_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .o_accepted     (res_accepted),
        .o_status       (res_status),
        .o_stored_count (res_count)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // book one request into table copy t and return the outcome
    function automatic booking_res_t book_interval(input int t, input t_time s, input t_time e);
        booking_res_t r;
        t_status      st;
        int unsigned  k, pos, left, right;
        bit           has_left, has_right;
        st        = ST_BOOKED;
        has_left  = 1'b0;
        has_right = 1'b0;
        left      = 0;
        right     = 0;
        if (e <= s) begin
            st = ST_RANGE;
        end else begin
            // overlap and touching neighbors over the whole table
            for (k = 0; k < slot_cnt[t]; k++) begin
                if (slot_lo[t][k] < e && s < slot_hi[t][k]) st = ST_OVERLAP;
                if (slot_hi[t][k] == s) begin
                    has_left = 1'b1;
                    left     = k;
                end
                if (slot_lo[t][k] == e) begin
                    has_right = 1'b1;
                    right     = k;
                end
            end
            if (st == ST_BOOKED) begin
                if (has_left && has_right) begin
                    // request bridges two entries: fold the right one into the left
                    slot_hi[t][left] = slot_hi[t][right];
                    for (k = right; k + 1 < slot_cnt[t]; k++) begin
                        slot_lo[t][k] = slot_lo[t][k+1];
                        slot_hi[t][k] = slot_hi[t][k+1];
                    end
                    slot_cnt[t]--;
                end else if (has_left) begin
                    slot_hi[t][left] = e;
                end else if (has_right) begin
                    slot_lo[t][right] = s;
                end else if (slot_cnt[t] >= MAX_INTERVALS) begin
                    st = ST_FULL;
                end else begin
                    // new entry at its sorted position
                    pos = 0;
                    while (pos < slot_cnt[t] && slot_lo[t][pos] < s) pos++;
                    for (k = slot_cnt[t]; k > pos; k--) begin
                        slot_lo[t][k] = slot_lo[t][k-1];
                        slot_hi[t][k] = slot_hi[t][k-1];
                    end
                    slot_lo[t][pos] = s;
                    slot_hi[t][pos] = e;
                    slot_cnt[t]++;
                end
            end
        end
        r.accepted = (st == ST_BOOKED);
        r.status   = st;
        r.count    = t_count'(slot_cnt[t]);
        return r;
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // interval length: mostly short, sometimes wide
    function automatic longint pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 16);
        if (r < 95) return $urandom_range(17, 4096);
        return $urandom_range(4097, 24'hFF_FFFF);
    endfunction

    task automatic queue_request(input t_time s, input t_time e);
        booking_res_t unused;
        pending_q.push_back('{start: s, stop: e});
        unused = book_interval(PLAN, s, e);
    endtask

    // one random request shaped by what the planner's table holds
    task automatic plan_random_request();
        int unsigned n, i, mode;
        longint      s, e, x, y, lo_lim, hi_lim;
        n    = slot_cnt[PLAN];
        mode = $urandom_range(99);
        s    = longint'($urandom);
        e    = s + pick_len();
        if (mode < 5) begin
            // empty or reversed range
            x = longint'($urandom);
            y = longint'($urandom);
            s = (x > y) ? x : y;
            e = (mode == 0) ? s : ((x > y) ? y : x);
        end else if (mode < 15 && n != 0) begin
            // starts inside a stored interval, or ends just inside it
            i      = $urandom_range(n - 1);
            lo_lim = slot_lo[PLAN][i];
            hi_lim = slot_hi[PLAN][i];
            s      = lo_lim + longint'($urandom) % (hi_lim - lo_lim);
            e      = s + pick_len();
            if ($urandom_range(1) == 1) begin
                x = pick_len();
                e = s + 1;
                s = (s > x) ? s - x : 0;
            end
        end else if (mode < 55) begin
            // fresh entry inside a gap, clear of both neighbors
            i      = $urandom_range(n);
            lo_lim = (i == 0) ? 0 : longint'(slot_hi[PLAN][i-1]) + 1;
            hi_lim = (i == n) ? TIME_TOP : longint'(slot_lo[PLAN][i]) - 1;
            if (hi_lim > lo_lim) begin
                s = lo_lim + longint'($urandom) % (hi_lim - lo_lim);
                e = s + pick_len();
                if (e > hi_lim) e = hi_lim;
            end
        end else if (mode < 70 && n != 0) begin
            // grow an entry at its end, at most up to the next one
            i      = $urandom_range(n - 1);
            s      = slot_hi[PLAN][i];
            hi_lim = (i + 1 < n) ? longint'(slot_lo[PLAN][i+1]) : TIME_TOP;
            e      = s + pick_len();
            if (e > hi_lim) e = hi_lim;
        end else if (mode < 85 && n != 0) begin
            // grow an entry at its start, at most down to the previous one
            i      = $urandom_range(n - 1);
            e      = slot_lo[PLAN][i];
            lo_lim = (i > 0) ? longint'(slot_hi[PLAN][i-1]) : 0;
            s      = e - pick_len();
            if (s < lo_lim) s = lo_lim;
        end else if (mode < 95 && n > 1) begin
            // exact fill of the gap between two entries
            i = $urandom_range(n - 2);
            s = slot_hi[PLAN][i];
            e = slot_lo[PLAN][i+1];
        end else if (mode >= 95) begin
            s = longint'($urandom);
            e = longint'($urandom);
        end
        queue_request(t_time'(s), t_time'(e));
    endtask

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_MAX) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // request driver: takes the next request once the current one is accepted
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && !req_stall) begin
                booked_q.push_back(book_interval(MODEL, req_start, req_end));
            end
            if (!req_valid || !req_stall) begin
                if (send_gap != 0) begin
                    req_valid <= 1'b0;
                    send_gap  <= send_gap - 1;
                end else if (pending_q.size() != 0) begin
                    req_valid <= 1'b1;
                    req_start <= pending_q[0].start;
                    req_end   <= pending_q[0].stop;
                    pending_q.pop_front();
                    // back-to-back bursts now and then
                    if (send_burst != 0) begin
                        send_gap   <= 0;
                        send_burst <= send_burst - 1;
                    end else begin
                        send_gap <= draw_gap();
                        if ($urandom_range(49) == 0) send_burst <= $urandom_range(20, 80);
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall) begin
                res_seen++;
                if (booked_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no request outstanding", res_seen));
                end else begin
                    head_res = booked_q.pop_front();
                    if (res_accepted !== head_res.accepted)
                        report_mismatch($sformatf("result %0d accepted %b, want %b",
                            res_seen, res_accepted, head_res.accepted));
                    if (res_status !== head_res.status)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                            res_seen, res_status, head_res.status));
                    if (res_count !== head_res.count)
                        report_mismatch($sformatf("result %0d stored count %0d, want %0d",
                            res_seen, res_count, head_res.count));
                end
            end
            if (hold_left != 0) begin
                res_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else begin
                res_stall <= 1'b0;
                if (calm_left != 0) begin
                    calm_left <= calm_left - 1;
                end else if ($urandom_range(199) == 0) begin
                    calm_left <= $urandom_range(40, 160);
                end else if ($urandom_range(3) == 0) begin
                    hold_left <= draw_gap();
                end
            end
        end
    end

    // stimulus, drain and verdict
    initial begin
        // range errors at the extremes
        queue_request(32'd5, 32'd5);
        queue_request(32'd10, 32'd3);
        queue_request(32'hFFFF_FFFF, 32'd0);
        queue_request(32'd0, 32'd0);
        queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // first entry, then overlaps from inside, from the left and from the right
        queue_request(32'd100, 32'd200);
        queue_request(32'd150, 32'd160);
        queue_request(32'd50, 32'd101);
        queue_request(32'd199, 32'd250);
        // grow at the end and at the start
        queue_request(32'd200, 32'd300);
        queue_request(32'd50, 32'd100);
        // new entry then a join of two neighbors
        queue_request(32'd400, 32'd500);
        queue_request(32'd300, 32'd400);
        // entries at both ends of the time range, a grow at the start, a whole-range overlap and a join
        queue_request(32'd0, 32'd1);
        queue_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        queue_request(32'hFFFF_FFF0, 32'hFFFF_FFFE);
        queue_request(32'd0, 32'hFFFF_FFFF);
        queue_request(32'd1, 32'd50);
        queue_request(32'd20, 32'd30);
        // separate entries then a bridging request
        queue_request(32'd600, 32'd700);
        queue_request(32'd800, 32'd900);
        queue_request(32'd700, 32'd800);
        queue_request(32'h8000_0000, 32'h8000_0001);
        repeat (N_RANDOM) plan_random_request();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || req_valid || booked_q.size() != 0) @(negedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0) begin
            $display("[interval_booking_table_unit] OK");
        end else begin
            $display("[interval_booking_table_unit] ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("[interval_booking_table_unit] ERROR");
        $finish;
    end

endmodule
